// ===== src/assert_macros.svh =====
// Assertion macros shared by the sequencer RTL.
// Needs nothing else; each macro wraps one concurrent assertion on a clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define I2CWS_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("i2cws: invariant violated");

// Consequent holds in the same cycle as the antecedent.
`define I2CWS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cws: implication violated");

// Consequent holds in the cycle after the antecedent.
`define I2CWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cws: next-cycle implication violated");

`endif

// ===== src/i2cws_pkg.sv =====
// Types, codes and constants of the I2C write-then-read sequencer.
// Used by the step logic and the top level; depends on nothing.
package i2cws_pkg;

    localparam int WRITE_DEPTH_DEFAULT = 16;

    // Request modes.
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_STATUS = 2'd2;

    // Bus controller status codes.
    localparam logic [7:0] ST_START        = 8'h08;
    localparam logic [7:0] ST_REP_START    = 8'h10;
    localparam logic [7:0] ST_SLAW_ACK     = 8'h18;
    localparam logic [7:0] ST_SLAW_NACK    = 8'h20;
    localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
    localparam logic [7:0] ST_SLAR_ACK     = 8'h40;
    localparam logic [7:0] ST_SLAR_NACK    = 8'h48;
    localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

    // Acknowledge actions.
    localparam logic [1:0] ACK_NONE   = 2'd0;
    localparam logic [1:0] ACK_ASSERT = 2'd1;
    localparam logic [1:0] ACK_CLEAR  = 2'd2;

    // Transfer outcomes.
    localparam logic [1:0] OUTCOME_OK       = 2'd0;
    localparam logic [1:0] OUTCOME_ADDR_NAK = 2'd1;
    localparam logic [1:0] OUTCOME_BAD_CODE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TARGET_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_WRITE_LENGTH   = 2'd1;
    localparam logic [1:0] CFG_READ_LENGTH    = 2'd2;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] status_code;
        logic [7:0] rx_byte;
        logic [3:0] load_index;
        logic [7:0] load_byte;
    } t_in_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic [1:0] ack_action;
        logic       clear_interrupt;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] read_position;
        logic       transfer_done;
        logic [1:0] outcome;
    } t_out_item;

    typedef struct packed {
        logic [1:0] index;
        logic [7:0] data;
    } t_cfg_beat;

    typedef struct packed {
        logic [7:0] target_address;
        logic [4:0] write_length;
        logic [7:0] read_length;
    } t_cfg_regs;

endpackage

// ===== src/i2cws_chan_if.sv =====
// Valid/ready channel carrying one payload beat per handshake.
// Payload type is supplied by the instantiating code, usually from i2cws_pkg.
interface i2cws_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/i2cws_step.sv =====
// Status decision logic with the write store and the write and read indexes.
// Depends on i2cws_pkg and assert_macros.svh; result is combinational, state updates on i_en.
`include "assert_macros.svh"

module i2cws_step import i2cws_pkg::*; #(
    parameter int WRITE_DEPTH = WRITE_DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_in_item  i_item,
    input  t_cfg_regs i_cfg,
    output t_out_item o_result
);
    localparam int AW = (WRITE_DEPTH > 1) ? $clog2(WRITE_DEPTH) : 1;
    localparam logic [8:0] DEPTH9 = 9'(WRITE_DEPTH);

    logic [7:0] r_store [WRITE_DEPTH];
    logic [4:0] r_write_index;
    logic [7:0] r_read_index;
    logic [4:0] n_write_index;
    logic [7:0] n_read_index;

    logic [8:0]    wl9;
    logic [8:0]    write_limit;
    logic [8:0]    wi9;
    logic [8:0]    li9;
    logic          more_to_write;
    logic          load_ok;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic [7:0]    read_inc;
    logic [1:0]    ack_now;
    logic [1:0]    ack_after;
    t_out_item     res;

    assign wl9           = {4'b0, i_cfg.write_length};
    assign write_limit   = (wl9 > DEPTH9) ? DEPTH9 : wl9;
    assign wi9           = {4'b0, r_write_index};
    assign li9           = {5'b0, i_item.load_index};
    assign more_to_write = wi9 < write_limit;
    assign load_ok       = li9 < DEPTH9;
    assign rd_idx        = wi9[AW-1:0];
    assign wr_idx        = li9[AW-1:0];
    assign read_inc      = r_read_index + 8'd1;

    // Acknowledge the coming byte only if at least one more byte follows it.
    assign ack_now   = (({1'b0, r_read_index} + 9'd1) < {1'b0, i_cfg.read_length})
                       ? ACK_ASSERT : ACK_CLEAR;
    assign ack_after = (({1'b0, read_inc} + 9'd1) < {1'b0, i_cfg.read_length})
                       ? ACK_ASSERT : ACK_CLEAR;

    always_comb begin
        res           = '0;
        n_write_index = r_write_index;
        n_read_index  = r_read_index;
        unique case (i_item.mode)
            MODE_START: begin
                res.set_start = 1'b1;
            end
            MODE_STATUS: begin
                res.clear_interrupt = 1'b1;
                unique case (i_item.status_code) inside
                    ST_START: begin
                        n_write_index   = '0;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = i_cfg.target_address;
                        res.clear_start = 1'b1;
                    end
                    ST_REP_START: begin
                        n_read_index    = '0;
                        res.tx_valid    = 1'b1;
                        res.tx_byte     = i_cfg.target_address | 8'h01;
                        res.clear_start = 1'b1;
                    end
                    ST_SLAW_ACK, ST_DATA_TX_ACK: begin
                        if (more_to_write) begin
                            res.tx_valid  = 1'b1;
                            res.tx_byte   = r_store[rd_idx];
                            n_write_index = r_write_index + 5'd1;
                        end else if (i_cfg.read_length != 8'd0) begin
                            res.set_start = 1'b1;
                        end else begin
                            res.set_stop      = 1'b1;
                            res.transfer_done = 1'b1;
                            res.outcome       = OUTCOME_OK;
                        end
                    end
                    ST_SLAR_ACK: begin
                        res.ack_action = ack_now;
                    end
                    ST_DATA_RX_ACK: begin
                        res.read_valid    = 1'b1;
                        res.read_byte     = i_item.rx_byte;
                        res.read_position = r_read_index;
                        n_read_index      = read_inc;
                        res.ack_action    = ack_after;
                    end
                    ST_DATA_RX_NACK: begin
                        res.read_valid    = 1'b1;
                        res.read_byte     = i_item.rx_byte;
                        res.read_position = r_read_index;
                        n_read_index      = read_inc;
                        res.set_stop      = 1'b1;
                        res.transfer_done = 1'b1;
                        res.outcome       = OUTCOME_OK;
                    end
                    ST_SLAW_NACK, ST_SLAR_NACK: begin
                        res.set_stop      = 1'b1;
                        res.transfer_done = 1'b1;
                        res.outcome       = OUTCOME_ADDR_NAK;
                    end
                    default: begin
                        res.set_stop      = 1'b1;
                        res.transfer_done = 1'b1;
                        res.outcome       = OUTCOME_BAD_CODE;
                    end
                endcase
            end
            default: begin
                // Loads and the unused mode give an all-zero result.
            end
        endcase
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_index <= '0;
            r_read_index  <= '0;
        end else if (i_en) begin
            r_write_index <= n_write_index;
            r_read_index  <= n_read_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_item.mode == MODE_LOAD && load_ok) begin
            r_store[wr_idx] <= i_item.load_byte;
        end
    end

    // The write index only advances below the clamped length, so it never passes the depth.
    `I2CWS_ASSERT_HOLDS(a_write_index_bound, i_clk, i_rst_n, wi9 <= DEPTH9)
    `I2CWS_ASSERT_NEXT(a_start_clears_index, i_clk, i_rst_n, i_en && i_item.mode == MODE_STATUS && i_item.status_code == ST_START, r_write_index == 5'd0)

endmodule

// ===== src/i2c_master_write_read_sequencer.sv =====
// Top level of the I2C write-then-read sequencer: channel registers and configuration.
// Depends on i2cws_pkg, i2cws_chan_if, i2cws_step and assert_macros.svh.
//
//   channel  direction  payload      purpose
//   i_cfg    in         t_cfg_beat   register writes (index, data)
//   i_req    in         t_in_item    start, store load and status requests
//   o_rsp    out        t_out_item   one controller action set per request
//
// A request sits in the input register and its result is registered at the
// output; one request per cycle.
// The two stages move together and stall only while a result waits on o_rsp.ready.
// Configuration writes are always taken. Reset is synchronous and active low; it clears
// the registers, the indexes and both valid flags; the write store is not cleared.
`include "assert_macros.svh"

module i2c_master_write_read_sequencer import i2cws_pkg::*; #(
    parameter int WRITE_DEPTH = WRITE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    i2cws_chan_if.sink    i_cfg,
    i2cws_chan_if.sink    i_req,
    i2cws_chan_if.source  o_rsp
);
    t_cfg_regs r_cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;

    logic      advance;
    logic      in_accept;
    t_out_item step_result;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || advance;
    assign in_accept   = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.payload.index)
                CFG_TARGET_ADDRESS: r_cfg.target_address <= i_cfg.payload.data;
                CFG_WRITE_LENGTH:   r_cfg.write_length   <= i_cfg.payload.data[4:0];
                CFG_READ_LENGTH:    r_cfg.read_length    <= i_cfg.payload.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_item <= i_req.payload;
        end
    end

    i2cws_step #(
        .WRITE_DEPTH (WRITE_DEPTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance && r_in_valid),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_item <= step_result;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out_item;

    `I2CWS_ASSERT_IMP(a_done_stops, i_clk, i_rst_n, r_out_valid && r_out_item.transfer_done, r_out_item.set_stop)
    `I2CWS_ASSERT_IMP(a_outcome_needs_done, i_clk, i_rst_n, r_out_valid && r_out_item.outcome != OUTCOME_OK, r_out_item.transfer_done)
    `I2CWS_ASSERT_IMP(a_tx_rx_exclusive, i_clk, i_rst_n, r_out_valid, !(r_out_item.tx_valid && r_out_item.read_valid))
    `I2CWS_ASSERT_IMP(a_no_accept_when_full, i_clk, i_rst_n, in_accept, !(r_in_valid && r_out_valid && !o_rsp.ready))

endmodule

// ===== bench/i2cws_action_checker.sv =====
// Checker for the I2C write-then-read sequencer: watches the config, request and result channels.
// Predicts the controller actions for every accepted request and compares them in order.
// Depends on i2cws_pkg for the beat types, status codes and register indexes.
module i2cws_action_checker import i2cws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  t_cfg_beat i_cfg_beat,
    input  logic      i_req_valid,
    input  logic      i_req_ready,
    input  t_in_item  i_req_item,
    input  logic      i_rsp_valid,
    input  logic      i_rsp_ready,
    input  t_out_item i_rsp_item,
    output int        o_fail_count,
    output int        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg_regs   regs;
    logic [7:0]  tx_store [WRITE_DEPTH_DEFAULT];
    logic [4:0]  tx_pos;
    logic [7:0]  rx_pos;
    t_out_item   expected_actions [$];
    int          fails = 0;

    // Keep acknowledging while at least one more byte is to follow the next one.
    function automatic logic [1:0] ack_for_next();
        return ({1'b0, rx_pos} + 9'd1 < {1'b0, regs.read_length}) ? ACK_ASSERT : ACK_CLEAR;
    endfunction

    function automatic t_out_item predict_action(t_in_item req);
        t_out_item act;
        int        tx_limit;
        act = '0;
        tx_limit = (regs.write_length > WRITE_DEPTH_DEFAULT) ? WRITE_DEPTH_DEFAULT
                                                             : int'(regs.write_length);
        case (req.mode)
            MODE_START: begin
                act.set_start = 1'b1;
            end
            MODE_LOAD: begin
                tx_store[req.load_index] = req.load_byte;
            end
            MODE_STATUS: begin
                act.clear_interrupt = 1'b1;
                case (req.status_code)
                    ST_START: begin
                        tx_pos = '0;
                        act.tx_valid = 1'b1;
                        act.tx_byte = regs.target_address;
                        act.clear_start = 1'b1;
                    end
                    ST_REP_START: begin
                        rx_pos = '0;
                        act.tx_valid = 1'b1;
                        act.tx_byte = regs.target_address | 8'h01;
                        act.clear_start = 1'b1;
                    end
                    ST_SLAW_ACK, ST_DATA_TX_ACK: begin
                        if (int'(tx_pos) < tx_limit) begin
                            act.tx_valid = 1'b1;
                            act.tx_byte = tx_store[tx_pos];
                            tx_pos = tx_pos + 5'd1;
                        end else if (regs.read_length != 8'd0) begin
                            act.set_start = 1'b1;
                        end else begin
                            act.set_stop = 1'b1;
                            act.transfer_done = 1'b1;
                            act.outcome = OUTCOME_OK;
                        end
                    end
                    ST_SLAR_ACK: begin
                        act.ack_action = ack_for_next();
                    end
                    ST_DATA_RX_ACK: begin
                        act.read_valid = 1'b1;
                        act.read_byte = req.rx_byte;
                        act.read_position = rx_pos;
                        rx_pos = rx_pos + 8'd1;
                        act.ack_action = ack_for_next();
                    end
                    ST_DATA_RX_NACK: begin
                        act.read_valid = 1'b1;
                        act.read_byte = req.rx_byte;
                        act.read_position = rx_pos;
                        rx_pos = rx_pos + 8'd1;
                        act.set_stop = 1'b1;
                        act.transfer_done = 1'b1;
                        act.outcome = OUTCOME_OK;
                    end
                    ST_SLAW_NACK, ST_SLAR_NACK: begin
                        act.set_stop = 1'b1;
                        act.transfer_done = 1'b1;
                        act.outcome = OUTCOME_ADDR_NAK;
                    end
                    default: begin
                        act.set_stop = 1'b1;
                        act.transfer_done = 1'b1;
                        act.outcome = OUTCOME_BAD_CODE;
                    end
                endcase
            end
            default: begin
            end
        endcase
        return act;
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_val,
                               input logic [7:0] act_val);
        if (act_val !== exp_val) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_val, act_val);
        end
    endtask

    task automatic compare_action(input t_out_item exp_act, input t_out_item got);
        check_field("tx_valid", 8'(exp_act.tx_valid), 8'(got.tx_valid));
        check_field("tx_byte", exp_act.tx_byte, got.tx_byte);
        check_field("set_start", 8'(exp_act.set_start), 8'(got.set_start));
        check_field("clear_start", 8'(exp_act.clear_start), 8'(got.clear_start));
        check_field("set_stop", 8'(exp_act.set_stop), 8'(got.set_stop));
        check_field("ack_action", 8'(exp_act.ack_action), 8'(got.ack_action));
        check_field("clear_interrupt", 8'(exp_act.clear_interrupt), 8'(got.clear_interrupt));
        check_field("read_valid", 8'(exp_act.read_valid), 8'(got.read_valid));
        check_field("read_byte", exp_act.read_byte, got.read_byte);
        check_field("read_position", exp_act.read_position, got.read_position);
        check_field("transfer_done", 8'(exp_act.transfer_done), 8'(got.transfer_done));
        check_field("outcome", 8'(exp_act.outcome), 8'(got.outcome));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs = '0;
            tx_pos = '0;
            rx_pos = '0;
            expected_actions.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1) begin
                case (i_cfg_beat.index)
                    CFG_TARGET_ADDRESS: regs.target_address = i_cfg_beat.data;
                    CFG_WRITE_LENGTH:   regs.write_length = i_cfg_beat.data[4:0];
                    CFG_READ_LENGTH:    regs.read_length = i_cfg_beat.data;
                    default: begin
                    end
                endcase
            end
            if (i_rsp_valid === 1'b1 && i_rsp_ready === 1'b1) begin
                if (expected_actions.size() == 0) begin
                    fails++;
                    $display("%0t: result beat with nothing expected, expected none, actual %h",
                             $time, i_rsp_item);
                end else begin
                    compare_action(expected_actions.pop_front(), i_rsp_item);
                end
            end
            if (i_req_valid === 1'b1 && i_req_ready === 1'b1)
                expected_actions.push_back(predict_action(i_req_item));
        end
        o_pending <= expected_actions.size();
        o_fail_count <= fails;
    end
endmodule

// ===== bench/tb_top.sv =====
// Top of the sequencer testbench: clock, reset, stimulus on the request and config channels.
// Depends on i2cws_pkg, i2cws_chan_if, the sequencer RTL and i2cws_action_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import i2cws_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int ITEM_TARGET = 1750;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    int   sent = 0;
    int   cur_wl = 0;
    int   cur_rl = 0;
    bit   calm = 1'b0;

    i2cws_chan_if #(.t_payload(t_cfg_beat)) cfg_chan ();
    i2cws_chan_if #(.t_payload(t_in_item))  req_chan ();
    i2cws_chan_if #(.t_payload(t_out_item)) rsp_chan ();

    i2c_master_write_read_sequencer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_chan),
        .i_req   (req_chan),
        .o_rsp   (rsp_chan)
    );

    i2cws_action_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (cfg_chan.valid),
        .i_cfg_ready  (cfg_chan.ready),
        .i_cfg_beat   (cfg_chan.payload),
        .i_req_valid  (req_chan.valid),
        .i_req_ready  (req_chan.ready),
        .i_req_item   (req_chan.payload),
        .i_rsp_valid  (rsp_chan.valid),
        .i_rsp_ready  (rsp_chan.ready),
        .i_rsp_item   (rsp_chan.payload),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none at all in a calm phase.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // Result side: ready runs of random length broken by stalls.
    initial begin
        int unsigned run_len;
        int unsigned stall_len;
        forever begin
            run_len = ($urandom_range(9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            rsp_chan.ready <= 1'b1;
            repeat (run_len) @(posedge i_clk);
            stall_len = pick_gap();
            if (stall_len != 0) begin
                rsp_chan.ready <= 1'b0;
                repeat (stall_len) @(posedge i_clk);
            end
        end
    end

    function automatic t_in_item make_item(input logic [1:0] mode);
        t_in_item it;
        it.mode = mode;
        it.status_code = 8'($urandom);
        it.rx_byte = 8'($urandom);
        it.load_index = 4'($urandom);
        it.load_byte = 8'($urandom);
        return it;
    endfunction

    function automatic t_in_item status_item(input logic [7:0] code);
        t_in_item it;
        it = make_item(MODE_STATUS);
        it.status_code = code;
        return it;
    endfunction

    function automatic t_in_item noise_item();
        t_in_item it;
        it = make_item(2'($urandom_range(3)));
        if ($urandom_range(1) == 0) begin
            case ($urandom_range(8))
                0: it.status_code = ST_START;
                1: it.status_code = ST_REP_START;
                2: it.status_code = ST_SLAW_ACK;
                3: it.status_code = ST_SLAW_NACK;
                4: it.status_code = ST_DATA_TX_ACK;
                5: it.status_code = ST_SLAR_ACK;
                6: it.status_code = ST_SLAR_NACK;
                7: it.status_code = ST_DATA_RX_ACK;
                default: it.status_code = ST_DATA_RX_NACK;
            endcase
        end
        return it;
    endfunction

    // A valid that stays high for the next beat is never lowered in between.
    task automatic send_req(input t_in_item it);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_chan.valid <= 1'b1;
        req_chan.payload <= it;
        do @(posedge i_clk); while (req_chan.ready !== 1'b1);
        sent++;
    endtask

    task automatic send_status(input logic [7:0] code);
        send_req(status_item(code));
    endtask

    // Hold off until every expected result has come back.
    task automatic drain();
        req_chan.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [1:0] idx, input logic [7:0] data);
        t_cfg_beat beat;
        beat.index = idx;
        beat.data = data;
        cfg_chan.valid <= 1'b1;
        cfg_chan.payload <= beat;
        do @(posedge i_clk); while (cfg_chan.ready !== 1'b1);
    endtask

    task automatic apply_config(input int ta, input int wl, input int rl);
        cfg_beat(CFG_TARGET_ADDRESS, 8'(ta));
        cfg_beat(CFG_WRITE_LENGTH, 8'(wl));
        cfg_beat(CFG_READ_LENGTH, 8'(rl));
        cfg_chan.valid <= 1'b0;
        cur_wl = wl;
        cur_rl = rl;
        @(posedge i_clk);
    endtask

    // One write-then-read transfer as the bus would report it, sometimes cut short by
    // a not-acknowledge or a stray code, sometimes with unrelated requests mixed in.
    task automatic run_transfer();
        logic [7:0]  codes [$];
        int unsigned nw;
        int unsigned r;
        int unsigned cut;
        bit          noisy;
        int          i;
        nw = (cur_wl > WRITE_DEPTH_DEFAULT) ? WRITE_DEPTH_DEFAULT : cur_wl;
        codes.push_back(ST_START);
        for (i = 0; i < int'(nw); i++)
            codes.push_back((i == 0) ? ST_SLAW_ACK : ST_DATA_TX_ACK);
        codes.push_back((nw == 0) ? ST_SLAW_ACK : ST_DATA_TX_ACK);
        if (cur_rl != 0) begin
            codes.push_back(ST_REP_START);
            codes.push_back(ST_SLAR_ACK);
            for (i = 1; i < cur_rl; i++)
                codes.push_back(ST_DATA_RX_ACK);
            codes.push_back(ST_DATA_RX_NACK);
        end
        r = $urandom_range(99);
        if (r >= 75 && r < 92) begin
            cut = $urandom_range(1, codes.size() - 1);
            while (codes.size() > cut)
                codes.delete(codes.size() - 1);
            if (r < 85)
                codes.push_back(($urandom_range(1) == 0) ? ST_SLAW_NACK : ST_SLAR_NACK);
            else
                codes.push_back(8'($urandom_range(255)));
        end
        noisy = (r >= 92);
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) send_req(make_item(MODE_LOAD));
        send_req(make_item(MODE_START));
        foreach (codes[k]) begin
            if (noisy && $urandom_range(4) == 0)
                send_req(noise_item());
            send_status(codes[k]);
        end
    endtask

    task automatic random_config();
        int unsigned r;
        int          ta;
        int          wl;
        int          rl;
        r = $urandom_range(99);
        ta = (r < 10) ? 0 : (r < 20) ? 254 : $urandom_range(0, 254);
        r = $urandom_range(99);
        wl = (r < 10) ? 0 : (r < 20) ? 16 : (r < 25) ? $urandom_range(17, 31)
                                                     : $urandom_range(0, 16);
        r = $urandom_range(99);
        rl = (r < 15) ? 0 : (r < 19) ? 255 : (r < 25) ? $urandom_range(9, 254)
                                                      : $urandom_range(1, 8);
        apply_config(ta, wl, rl);
    endtask

    initial begin
        t_in_item it;
        int       i;
        i_rst_n = 1'b0;
        cfg_chan.valid <= 1'b0;
        cfg_chan.payload <= '0;
        req_chan.valid <= 1'b0;
        req_chan.payload <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero lengths and address zero: stray codes, both address NACKs, unused mode.
        apply_config(0, 0, 0);
        send_req(make_item(MODE_START));
        send_status(ST_START);
        send_status(ST_SLAW_ACK);
        send_status(ST_SLAW_NACK);
        send_status(ST_SLAR_NACK);
        send_status(ST_REP_START);
        send_status(ST_SLAR_ACK);
        send_status(ST_DATA_RX_ACK);
        send_status(ST_DATA_RX_NACK);
        send_req(make_item(2'd3));
        send_status(8'hFF);
        send_status(8'h00);

        // Fill the whole write store so that no transfer can send an unwritten entry.
        for (i = 0; i < WRITE_DEPTH_DEFAULT; i++) begin
            it = make_item(MODE_LOAD);
            it.load_index = 4'(i);
            it.load_byte = (i == 0) ? 8'h00 : (i == WRITE_DEPTH_DEFAULT - 1) ? 8'hFF
                                                                           : 8'($urandom);
            send_req(it);
        end
        drain();

        // Highest address, over-long write length and a single-byte read.
        apply_config(254, 31, 1);
        run_transfer();
        drain();

        // Long read that runs past the configured length so that the position wraps.
        apply_config(8'h3C, 0, 255);
        send_status(ST_REP_START);
        send_status(ST_SLAR_ACK);
        repeat (300) send_status(ST_DATA_RX_ACK);
        send_status(ST_DATA_RX_NACK);

        while (sent < ITEM_TARGET) begin
            drain();
            random_config();
            calm = ($urandom_range(7) == 0);
            if (cur_rl > 8)
                run_transfer();
            else
                repeat ($urandom_range(2, 6)) run_transfer();
        end
        calm = 1'b0;

        drain();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
